/* design/swk_pkg.sv */
// Shared types, widths and constants for the swerve wheel kinematics block.
// Used by every module under design/; depends on nothing.
package swk_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int RATIO_BITS  = 15;
    localparam int RATIO_FRAC  = 14;
    localparam int AXIS_W      = 32;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam int CW          = 36;
    localparam int ANG_W       = 32;
    localparam int ANGLE_STEPS = 16;
    localparam int ANG_DLY     = SQRT_STEPS - ANGLE_STEPS;
    localparam int DIV_STEPS   = SAMPLE_BITS;
    localparam int NUM_W       = 48;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int BACK_STAGES = 2 + SQRT_STEPS + 3 + DIV_STEPS + 1;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [RATIO_BITS-1:0] LENGTH_RESET = 15'd25588;
    localparam logic [RATIO_BITS-1:0] WIDTH_RESET  = 15'd20470;
    localparam logic [CFG_IDX_W-1:0]  CFG_LENGTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_WIDTH    = 8'd1;

    // Speed of one in the Q.29 magnitude scale.
    localparam logic [ROOT_W-1:0] MAG_ONE = 32'h2000_0000;

    localparam logic [ANG_W-1:0] ANG_QUARTER  = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_MQUARTER = 32'hC000_0000;

    // atan(2^-i) in 32-bit binary angle units.
    localparam logic [ANG_W-1:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // The four mixed axes of one command, all in Q.29.
    typedef struct packed {
        logic signed [AXIS_W-1:0] a;
        logic signed [AXIS_W-1:0] b;
        logic signed [AXIS_W-1:0] c;
        logic signed [AXIS_W-1:0] d;
    } t_axes;

endpackage

/* design/swk_front.sv */
// Front end: accepts a drive command and forms the four mixed axes.
// Depends on swk_pkg.
module swk_front (
    input  logic                                 i_valid,
    input  logic                                 i_queue_full,
    input  logic signed [swk_pkg::SAMPLE_BITS-1:0] i_rotation,
    input  logic signed [swk_pkg::SAMPLE_BITS-1:0] i_strafe_x,
    input  logic signed [swk_pkg::SAMPLE_BITS-1:0] i_forward_y,
    input  logic [swk_pkg::RATIO_BITS-1:0]       i_length_ratio,
    input  logic [swk_pkg::RATIO_BITS-1:0]       i_width_ratio,
    output logic                                 o_ready,
    output logic                                 o_push,
    output swk_pkg::t_axes                       o_axes
);
    logic signed [swk_pkg::AXIS_W-1:0] w_rl, w_rw, w_x, w_y;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Ratios are unsigned, so they enter the product with a zero sign bit.
    assign w_rl = i_rotation * $signed({1'b0, i_length_ratio});
    assign w_rw = i_rotation * $signed({1'b0, i_width_ratio});
    assign w_x  = swk_pkg::AXIS_W'(i_strafe_x)  <<< swk_pkg::RATIO_FRAC;
    assign w_y  = swk_pkg::AXIS_W'(i_forward_y) <<< swk_pkg::RATIO_FRAC;

    assign o_axes.a = w_x - w_rl;
    assign o_axes.b = w_x + w_rl;
    assign o_axes.c = w_y - w_rw;
    assign o_axes.d = w_y + w_rw;
endmodule

/* design/swk_queue.sv */
// Short queue between the front end and the wheel datapath.
// Depends on swk_pkg.
module swk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swk_pkg::t_axes i_data,
    input  logic           i_pop,
    output swk_pkg::t_axes o_data,
    output logic           o_empty,
    output logic           o_full
);
    swk_pkg::t_axes r_mem [swk_pkg::QDEPTH];
    logic [swk_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [swk_pkg::QPTR_W:0]   r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (swk_pkg::QPTR_W+1)'(swk_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

/* design/swk_wheel.sv */
// One wheel lane: squared length, pipelined integer square root and CORDIC angle.
// Depends on swk_pkg.
module swk_wheel (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [swk_pkg::AXIS_W-1:0]   i_px,
    input  logic signed [swk_pkg::AXIS_W-1:0]   i_py,
    output logic [swk_pkg::ROOT_W-1:0]          o_mag,
    output logic [swk_pkg::SAMPLE_BITS-1:0]     o_angle
);
    localparam int SS = swk_pkg::SQRT_STEPS;
    localparam int AS = swk_pkg::ANGLE_STEPS;
    localparam int CW = swk_pkg::CW;

    logic signed [swk_pkg::SQ_W-1:0]   w_sqp, w_sqq;
    logic signed [swk_pkg::AXIS_W-1:0] r_px1, r_py1;
    logic [swk_pkg::SQ_W-1:0]          r_sqp, r_sqq, r_sum;

    logic [swk_pkg::REM_W-1:0]  r_rem  [SS], n_rem  [SS];
    logic [swk_pkg::ROOT_W-1:0] r_root [SS], n_root [SS];
    logic [swk_pkg::SQ_W-1:0]   r_val  [SS], n_val  [SS];

    logic signed [CW-1:0]         r_cx [0:AS], r_cy [0:AS], n_cx [0:AS], n_cy [0:AS];
    logic [swk_pkg::ANG_W-1:0]    r_ca [0:AS], n_ca [0:AS];
    logic                         r_cz [0:AS], n_cz;
    logic [swk_pkg::ANG_W-1:0]    w_round;
    logic [swk_pkg::SAMPLE_BITS-1:0] r_adly [swk_pkg::ANG_DLY];

    assign w_sqp = i_px * i_px;
    assign w_sqq = i_py * i_py;

    // Digit-by-digit root, two radicand bits per stage.
    always_comb begin
        logic [swk_pkg::REM_W+1:0] rem_t, trial;
        logic [swk_pkg::REM_W-1:0] rem_i;
        logic [swk_pkg::ROOT_W-1:0] root_i;
        logic [swk_pkg::SQ_W-1:0] val_i;
        for (int k = 0; k < SS; k++) begin
            rem_i  = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
            root_i = (k == 0) ? '0 : r_root[(k == 0) ? 0 : k-1];
            val_i  = (k == 0) ? r_sum : r_val[(k == 0) ? 0 : k-1];
            rem_t  = {rem_i, val_i[swk_pkg::SQ_W-1 -: 2]};
            trial  = {2'b00, root_i, 2'b01};
            n_val[k] = val_i << 2;
            if (rem_t >= trial) begin
                n_rem[k]  = swk_pkg::REM_W'(rem_t - trial);
                n_root[k] = {root_i[swk_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = swk_pkg::REM_W'(rem_t);
                n_root[k] = {root_i[swk_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Turn a left half-plane vector by a quarter turn, then vectoring steps.
    always_comb begin
        logic signed [CW-1:0] x0, y0;
        x0 = CW'(r_px1);
        y0 = CW'(r_py1);
        n_cz = (r_px1 == '0) && (r_py1 == '0);
        n_cx[0] = x0;
        n_cy[0] = y0;
        n_ca[0] = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_cx[0] = y0;
                n_cy[0] = -x0;
                n_ca[0] = swk_pkg::ANG_QUARTER;
            end else begin
                n_cx[0] = -y0;
                n_cy[0] = x0;
                n_ca[0] = swk_pkg::ANG_MQUARTER;
            end
        end
        for (int i = 0; i < AS; i++) begin
            if (r_cy[i] >= 0) begin
                n_cx[i+1] = r_cx[i] + (r_cy[i] >>> (i % 32));
                n_cy[i+1] = r_cy[i] - (r_cx[i] >>> (i % 32));
                n_ca[i+1] = r_ca[i] + swk_pkg::ATAN_TAB[i % 32];
            end else begin
                n_cx[i+1] = r_cx[i] - (r_cy[i] >>> (i % 32));
                n_cy[i+1] = r_cy[i] + (r_cx[i] >>> (i % 32));
                n_ca[i+1] = r_ca[i] - swk_pkg::ATAN_TAB[i % 32];
            end
        end
    end

    assign w_round = r_ca[AS] + (swk_pkg::ANG_W)'(1 << (swk_pkg::ANG_W - swk_pkg::SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px1 <= i_px;
            r_py1 <= i_py;
            r_sqp <= unsigned'(w_sqp);
            r_sqq <= unsigned'(w_sqq);
            r_sum <= r_sqp + r_sqq;
            for (int k = 0; k < SS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_val[k]  <= n_val[k];
            end
            r_cx[0] <= n_cx[0];
            r_cy[0] <= n_cy[0];
            r_ca[0] <= n_ca[0];
            r_cz[0] <= n_cz;
            for (int i = 0; i < AS; i++) begin
                r_cx[i+1] <= n_cx[i+1];
                r_cy[i+1] <= n_cy[i+1];
                r_ca[i+1] <= n_ca[i+1];
                r_cz[i+1] <= r_cz[i];
            end
            r_adly[0] <= r_cz[AS] ? '0 : w_round[swk_pkg::ANG_W-1 -: swk_pkg::SAMPLE_BITS];
            for (int j = 1; j < swk_pkg::ANG_DLY; j++) begin
                r_adly[j] <= r_adly[j-1];
            end
        end
    end

    assign o_mag   = r_root[SS-1];
    assign o_angle = r_adly[swk_pkg::ANG_DLY-1];
endmodule

/* design/swk_norm.sv */
// Speed scaling: largest of four magnitudes, then pipelined restoring divide, used only when the largest exceeds one.
// Depends on swk_pkg.
module swk_norm (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [3:0][swk_pkg::ROOT_W-1:0]           i_mag,
    input  logic [3:0][swk_pkg::SAMPLE_BITS-1:0]      i_angle,
    output logic [3:0][swk_pkg::SAMPLE_BITS-1:0]      o_speed,
    output logic [3:0][swk_pkg::SAMPLE_BITS-1:0]      o_angle
);
    localparam int DS = swk_pkg::DIV_STEPS;
    localparam int SB = swk_pkg::SAMPLE_BITS;
    localparam int RW = swk_pkg::ROOT_W;
    localparam int NW = swk_pkg::NUM_W;

    logic [RW-1:0]          r_m01, r_m23, r_mx2;
    logic [3:0][RW-1:0]     r_mag1, r_mag2;
    logic [3:0][SB-1:0]     r_ang1, r_ang2;
    logic                   r_big2;

    logic [3:0][NW-1:0]     r_rem [0:DS], n_rem [1:DS];
    logic [3:0][SB-1:0]     r_q   [0:DS], n_q   [1:DS];
    logic [3:0][SB-1:0]     r_sp  [0:DS];
    logic [3:0][SB-1:0]     r_ang [0:DS];
    logic [RW-1:0]          r_mx  [0:DS];
    logic                   r_big [0:DS];
    logic [3:0][SB-1:0]     r_out_speed, r_out_angle;

    always_comb begin
        logic [NW-1:0] dvs;
        for (int j = 0; j < DS; j++) begin
            dvs = NW'(r_mx[j]) << (DS - 1 - j);
            for (int w = 0; w < 4; w++) begin
                n_rem[j+1][w] = r_rem[j][w];
                n_q[j+1][w]   = r_q[j][w];
                if (r_rem[j][w] >= dvs) begin
                    n_rem[j+1][w] = r_rem[j][w] - dvs;
                    n_q[j+1][w][DS-1-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RW-1:0] sum;
        if (i_en) begin
            r_m01  <= (i_mag[0] > i_mag[1]) ? i_mag[0] : i_mag[1];
            r_m23  <= (i_mag[2] > i_mag[3]) ? i_mag[2] : i_mag[3];
            r_mag1 <= i_mag;
            r_ang1 <= i_angle;
            r_mx2  <= (r_m01 > r_m23) ? r_m01 : r_m23;
            r_big2 <= ((r_m01 > r_m23) ? r_m01 : r_m23) > swk_pkg::MAG_ONE;
            r_mag2 <= r_mag1;
            r_ang2 <= r_ang1;
            for (int w = 0; w < 4; w++) begin
                r_rem[0][w] <= (NW'(r_mag2[w]) << (SB - 1)) + NW'(r_mx2 >> 1);
                sum = r_mag2[w] + RW'(1 << (swk_pkg::RATIO_FRAC - 1));
                r_sp[0][w]  <= sum[swk_pkg::RATIO_FRAC +: SB];
                r_q[0][w]   <= '0;
            end
            r_mx[0]  <= r_mx2;
            r_big[0] <= r_big2;
            r_ang[0] <= r_ang2;
            for (int j = 0; j < DS; j++) begin
                r_rem[j+1] <= n_rem[j+1];
                r_q[j+1]   <= n_q[j+1];
                r_sp[j+1]  <= r_sp[j];
                r_ang[j+1] <= r_ang[j];
                r_mx[j+1]  <= r_mx[j];
                r_big[j+1] <= r_big[j];
            end
            r_out_speed <= r_big[DS] ? r_q[DS] : r_sp[DS];
            r_out_angle <= r_ang[DS];
        end
    end

    assign o_speed = r_out_speed;
    assign o_angle = r_out_angle;
endmodule

/* design/swerve_wheel_kinematics.sv */
// Four-wheel swerve drive inverse kinematics, top level.
// Depends on swk_pkg, swk_front, swk_queue, swk_wheel and swk_norm.
//
// Usage:
//   A drive command (rotation, strafe X, forward Y, each signed Q1.15) enters
//   as one beat on the slave stream. One beat leaves on the master stream with
//   a speed (unsigned Q1.15) and a binary angle for each of the four wheels.
//   The chassis ratios are written on the configuration channel, which is
//   always ready; index 0 is the length ratio and index 1 the width ratio.
//   Writes to any other index are dropped.
//   The front end forms the mixed axes and pushes them into a four-entry
//   queue. The back end pops the queue and runs a fixed 54-stage pipeline:
//   squares, a 32-stage square root beside a 16-step CORDIC, the maximum,
//   and a 16-stage divider that scales the speeds when the largest exceeds one.
//   When the receiver is ready, one beat is accepted and delivered every cycle.
//   When the receiver stalls, the whole back pipeline holds, the queue fills,
//   and s_tready drops once the queue is full; nothing is lost.
//   Reset empties the queue and the pipeline and restores the ratios of a
//   30 by 24 chassis.
module swerve_wheel_kinematics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // rotation [15:0], strafe_x [31:16], forward_y [47:32]
    input  logic [3*swk_pkg::SAMPLE_BITS-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // speed_one, angle_one, speed_two, angle_two, speed_three, angle_three,
    // speed_four, angle_four, 16 bits each from bit 0 up
    output logic [8*swk_pkg::SAMPLE_BITS-1:0]   o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swk_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int SB = swk_pkg::SAMPLE_BITS;
    localparam int BS = swk_pkg::BACK_STAGES;

    logic [swk_pkg::RATIO_BITS-1:0] r_length, r_width;
    logic                           w_full, w_empty, w_push, w_pop, w_en;
    swk_pkg::t_axes                 w_axes_in, w_axes_out;
    logic [BS-1:0]                  r_vld;
    logic [3:0][swk_pkg::ROOT_W-1:0] w_mag;
    logic [3:0][SB-1:0]             w_angle, w_speed, w_angle_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= swk_pkg::LENGTH_RESET;
            r_width  <= swk_pkg::WIDTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == swk_pkg::CFG_LENGTH) begin
                r_length <= i_cfg_data[swk_pkg::RATIO_BITS-1:0];
            end else if (i_cfg_index == swk_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_data[swk_pkg::RATIO_BITS-1:0];
            end
        end
    end

    swk_front u_front (
        .i_valid        (i_s_tvalid),
        .i_queue_full   (w_full),
        .i_rotation     (i_s_tdata[SB-1:0]),
        .i_strafe_x     (i_s_tdata[2*SB-1:SB]),
        .i_forward_y    (i_s_tdata[3*SB-1:2*SB]),
        .i_length_ratio (r_length),
        .i_width_ratio  (r_width),
        .o_ready        (o_s_tready),
        .o_push         (w_push),
        .o_axes         (w_axes_in)
    );

    swk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_axes_in),
        .i_pop   (w_pop),
        .o_data  (w_axes_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // The back pipeline moves as one unit whenever its last stage can drain.
    assign w_en  = !r_vld[BS-1] || i_m_tready;
    assign w_pop = w_en && !w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[BS-2:0], w_pop};
        end
    end

    // Wheel one uses (B,C), two (B,D), three (A,D), four (A,C).
    swk_wheel u_wheel_one (
        .i_clk (i_clk), .i_en (w_en), .i_px (w_axes_out.b), .i_py (w_axes_out.c),
        .o_mag (w_mag[0]), .o_angle (w_angle[0])
    );
    swk_wheel u_wheel_two (
        .i_clk (i_clk), .i_en (w_en), .i_px (w_axes_out.b), .i_py (w_axes_out.d),
        .o_mag (w_mag[1]), .o_angle (w_angle[1])
    );
    swk_wheel u_wheel_three (
        .i_clk (i_clk), .i_en (w_en), .i_px (w_axes_out.a), .i_py (w_axes_out.d),
        .o_mag (w_mag[2]), .o_angle (w_angle[2])
    );
    swk_wheel u_wheel_four (
        .i_clk (i_clk), .i_en (w_en), .i_px (w_axes_out.a), .i_py (w_axes_out.c),
        .o_mag (w_mag[3]), .o_angle (w_angle[3])
    );

    swk_norm u_norm (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag   (w_mag),
        .i_angle (w_angle),
        .o_speed (w_speed),
        .o_angle (w_angle_out)
    );

    assign o_m_tvalid = r_vld[BS-1];
    assign o_m_tdata  = {w_angle_out[3], w_speed[3], w_angle_out[2], w_speed[2],
                         w_angle_out[1], w_speed[1], w_angle_out[0], w_speed[0]};
endmodule

/* bench/tb_swerve_wheel_kinematics.sv */
// Self-checking testbench for the swerve wheel kinematics block.
// Depends on swk_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_swerve_wheel_kinematics;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_CYC  = 80;
    localparam int PHASE_ITEMS = 370;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;     // rotation, strafe_x, forward_y from bit 0 up
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;     // speed/angle pairs for wheels one to four
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_data;

    int errors;
    int cmd_beats;
    int wheel_beats;
    int idle_cycles;
    bit quiet;   // when set, both sides run without gaps

    swerve_wheel_kinematics u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic void report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endfunction

    // Wheel predictor plus the queue of wheel beats still owed by the block.
    class wheel_scoreboard;
        bit [14:0]    len_ratio;
        bit [14:0]    wid_ratio;
        bit [127:0]   owed[$];

        function new();
            len_ratio = swk_pkg::LENGTH_RESET;
            wid_ratio = swk_pkg::WIDTH_RESET;
        endfunction

        function void write_reg(bit [7:0] idx, bit [15:0] val);
            if (idx == swk_pkg::CFG_LENGTH) len_ratio = val[14:0];
            else if (idx == swk_pkg::CFG_WIDTH) wid_ratio = val[14:0];
        endfunction

        function bit [63:0] root(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit [63:0] magnitude(longint p, longint q);
            bit [63:0] up;
            bit [63:0] uq;
            up = (p < 0) ? -p : p;
            uq = (q < 0) ? -q : q;
            return root(up * up + uq * uq);
        endfunction

        // Vectoring CORDIC; the left half-plane is pre-rotated by a quarter turn.
        function bit [15:0] heading(longint x, longint y);
            bit [31:0] ang;
            longint    t;
            longint    dx;
            longint    dy;
            ang = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; ang = swk_pkg::ANG_QUARTER;
                end else begin
                    t = x; x = -y; y = t; ang = swk_pkg::ANG_MQUARTER;
                end
            end
            for (int i = 0; i < swk_pkg::ANGLE_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; ang += swk_pkg::ATAN_TAB[i];
                end else begin
                    x -= dx; y += dy; ang -= swk_pkg::ATAN_TAB[i];
                end
            end
            ang = ang + 32'h0000_8000;
            return ang[31:16];
        endfunction

        function void note_command(bit [47:0] d);
            longint    r, x, y, rl, rw, a, b, c, e;
            longint    px[4];
            longint    py[4];
            bit [63:0] mag[4];
            bit [63:0] mx;
            bit [63:0] sp;
            bit [127:0] res;
            r  = longint'($signed(d[15:0]));
            x  = longint'($signed(d[31:16])) * 16384;
            y  = longint'($signed(d[47:32])) * 16384;
            rl = r * longint'(len_ratio);
            rw = r * longint'(wid_ratio);
            a = x - rl; b = x + rl; c = y - rw; e = y + rw;
            px[0] = b; py[0] = c;
            px[1] = b; py[1] = e;
            px[2] = a; py[2] = e;
            px[3] = a; py[3] = c;
            mx = 0;
            for (int k = 0; k < 4; k++) begin
                mag[k] = magnitude(px[k], py[k]);
                if (mag[k] > mx) mx = mag[k];
            end
            for (int k = 0; k < 4; k++) begin
                // Only a largest speed strictly above one triggers scaling.
                if (mx > 64'(swk_pkg::MAG_ONE)) sp = ((mag[k] << 15) + mx / 2) / mx;
                else sp = (mag[k] + 64'd8192) >> 14;
                res[32*k +: 16]      = sp[15:0];
                res[32*k + 16 +: 16] = heading(px[k], py[k]);
            end
            owed.push_back(res);
        endfunction

        function void check_wheels(bit [127:0] got);
            bit [127:0] want;
            string      nm;
            if (owed.size() == 0) begin
                report($sformatf("unexpected wheel beat %h", got));
                return;
            end
            want = owed.pop_front();
            for (int f = 0; f < 8; f++) begin
                nm = $sformatf("%s_%0d", (f % 2) ? "angle" : "speed", f / 2 + 1);
                if (got[16*f +: 16] !== want[16*f +: 16])
                    report($sformatf("%s got %0d want %0d", nm,
                                     got[16*f +: 16], want[16*f +: 16]));
            end
        endfunction
    endclass

    wheel_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // All handshakes are observed here, at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                sb.note_command(s_tdata);
                cmd_beats++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                sb.check_wheels(m_tdata);
                wheel_beats++;
                idle_cycles = 0;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("swerve_wheel_kinematics verification failed");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Receiver: each wheel beat may be preceded by a random stall.
    initial begin
        int gap;
        int seen;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            seen = wheel_beats;
            do @(negedge i_clk); while (wheel_beats == seen);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input logic [15:0] r, input logic [15:0] x,
                                input logic [15:0] y);
        int gap;
        int seen;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x, r};
        seen = cmd_beats;
        do @(negedge i_clk); while (cmd_beats == seen);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_field(int mode);
        logic [15:0] pick[5];
        pick = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 4000) - 2000);
            default: return pick[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic random_commands(input int count);
        int mode;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            // Hold off once mid-phase until the pipeline has fully emptied.
            if (n == count / 2) begin
                s_tvalid <= 1'b0;
                while (sb.owed.size() != 0) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            send_command(rand_field(mode), rand_field(mode), rand_field(mode));
        end
        quiet = 1'b0;
    endtask

    initial begin
        errors = 0; cmd_beats = 0; wheel_beats = 0; idle_cycles = 0; quiet = 1'b0;
        sb = new();
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands with the reset chassis ratios.
        send_command(16'h0000, 16'h0000, 16'h0000);   // zero vector on all wheels
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_command(16'h8000, 16'h8000, 16'h8000);
        send_command(16'h7FFF, 16'h0000, 16'h0000);   // pure spin, scaled down
        send_command(16'h8000, 16'h0000, 16'h0000);
        send_command(16'h0000, 16'h8000, 16'h0000);   // speed exactly one, half-turn
        send_command(16'h0000, 16'h0000, 16'h8000);   // speed exactly one, straight back
        send_command(16'h0000, 16'h7FFF, 16'h0000);
        send_command(16'h0000, 16'h0000, 16'h7FFF);
        send_command(16'h0000, 16'hFFFF, 16'h0000);   // tiny left vector, half-turn
        send_command(16'h0000, 16'h8000, 16'h8000);
        send_command(16'h0000, 16'h8000, 16'h7FFF);
        send_command(16'h0001, 16'hFFFF, 16'h0001);
        send_command(16'h4000, 16'hC000, 16'h2000);
        send_command(16'hC000, 16'h4000, 16'hE000);
        send_command(16'h5555, 16'hAAAA, 16'h5555);
        random_commands(PHASE_ITEMS);
        drain();

        // Zero ratios: rotation has no effect. Stray indexes must be dropped.
        write_reg(swk_pkg::CFG_LENGTH, 16'h0000);
        write_reg(swk_pkg::CFG_WIDTH, 16'h0000);
        write_reg(8'd2, 16'hFFFF);
        write_reg(8'hFF, 16'h1234);
        send_command(16'h7FFF, 16'h1000, 16'h2000);
        random_commands(PHASE_ITEMS);
        drain();

        // Largest ratios; bit 15 of the data is beyond the register.
        write_reg(swk_pkg::CFG_LENGTH, 16'hFFFF);
        write_reg(swk_pkg::CFG_WIDTH, 16'h7FFF);
        send_command(16'h7FFF, 16'h7FFF, 16'h8000);
        random_commands(PHASE_ITEMS);
        drain();

        // Lopsided chassis.
        write_reg(swk_pkg::CFG_LENGTH, 16'h7FFF);
        write_reg(swk_pkg::CFG_WIDTH, 16'h0001);
        random_commands(PHASE_ITEMS);
        drain();

        // Random chassis ratios.
        for (int p = 0; p < 2; p++) begin
            write_reg(swk_pkg::CFG_LENGTH, 16'($urandom));
            write_reg(swk_pkg::CFG_WIDTH, 16'($urandom));
            random_commands(PHASE_ITEMS / 2);
            drain();
        end

        if (errors == 0 && sb.owed.size() == 0) begin
            $display("swerve_wheel_kinematics verification clean");
        end else begin
            if (sb.owed.size() != 0)
                report($sformatf("%0d wheel beats never arrived", sb.owed.size()));
            $display("swerve_wheel_kinematics verification failed");
        end
        $finish;
    end

endmodule
